[rtl/stg_pkg.sv]
// stg_pkg: widths, codes and fixed-point helpers of the spline tangent generator
// used by spline_tangent_generator and stg_checker; no dependencies
package stg_pkg;

   // number formats
   localparam int POS_WIDTH  = 32;               // positions and tangents, Q.F
   localparam int FRAC_BITS  = 16;               // fraction bits
   localparam int REG_W      = FRAC_BITS + 2;    // tension, continuity, bias, Q1.F
   localparam int TERM_W     = FRAC_BITS + 3;    // one plus or minus a register
   localparam int COEF_W     = FRAC_BITS + 4;    // tangent weights
   localparam int SPAN_W     = POS_WIDTH + 1;    // exact end minus begin
   localparam int PAIR_W     = 2 * TERM_W;
   localparam int TRIPLE_W   = 3 * TERM_W;
   localparam int PROD_W     = COEF_W + SPAN_W;
   localparam int SUM_W      = PROD_W + 1;
   localparam int NUM_AXES   = 3;
   localparam int NUM_COEF   = 4;
   localparam int COEF_IDX_W = 2;
   localparam int STEP_W     = COEF_IDX_W + 1;   // two steps per weight

   // register port
   localparam int REG_IDX_W  = 2;
   localparam int CSR_ADDR_W = REG_IDX_W + 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [REG_IDX_W-1:0] REG_TENSION    = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_CONTINUITY = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_BIAS       = 2'd2;

   // result codes
   localparam logic KIND_BEGIN   = 1'b0;
   localparam logic KIND_END     = 1'b1;
   localparam logic SEG_CURRENT  = 1'b0;
   localparam logic SEG_PREVIOUS = 1'b1;

   typedef logic signed [POS_WIDTH-1:0] pos_type;
   typedef logic signed [SPAN_W-1:0]    span_type;
   typedef logic signed [REG_W-1:0]     reg_type;
   typedef logic signed [TERM_W-1:0]    term_type;
   typedef logic signed [COEF_W-1:0]    coef_type;
   typedef logic signed [PROD_W-1:0]    prod_type;
   typedef logic signed [SUM_W-1:0]     sum_type;
   typedef logic signed [PAIR_W-1:0]    pair_type;
   typedef logic signed [TRIPLE_W-1:0]  triple_type;

   localparam term_type ONE_TERM   = term_type'(1) << FRAC_BITS;
   localparam coef_type COEF_RESET = coef_type'(1) << (FRAC_BITS - 1);

   // round half up at bit 2F+1, saturate to a weight
   function automatic coef_type coef_round(input triple_type q);
      logic signed [TRIPLE_W:0]                  r;
      logic [TRIPLE_W-2*FRAC_BITS-COEF_W:0]      top;
      r = {q[TRIPLE_W-1], q} + ((TRIPLE_W+1)'(1) << (2 * FRAC_BITS));
      top = r[TRIPLE_W:2*FRAC_BITS+COEF_W];
      if ((&top) | ~(|top)) begin
         coef_round = r[2*FRAC_BITS+COEF_W:2*FRAC_BITS+1];
      end else if (r[TRIPLE_W]) begin
         coef_round = {1'b1, {(COEF_W-1){1'b0}}};
      end else begin
         coef_round = {1'b0, {(COEF_W-1){1'b1}}};
      end
   endfunction

   // round half up at bit F, saturate to a position
   function automatic pos_type tangent_round(input sum_type s);
      logic signed [SUM_W:0]                   r;
      logic [SUM_W-POS_WIDTH-FRAC_BITS+1:0]    top;
      r = {s[SUM_W-1], s} + ((SUM_W+1)'(1) << (FRAC_BITS - 1));
      top = r[SUM_W:POS_WIDTH+FRAC_BITS-1];
      if ((&top) | ~(|top)) begin
         tangent_round = r[POS_WIDTH+FRAC_BITS-1:FRAC_BITS];
      end else if (r[SUM_W]) begin
         tangent_round = {1'b1, {(POS_WIDTH-1){1'b0}}};
      end else begin
         tangent_round = {1'b0, {(POS_WIDTH-1){1'b1}}};
      end
   endfunction

   // span clipped to a position
   function automatic pos_type span_sat(input span_type s);
      if (s[SPAN_W-1] == s[SPAN_W-2]) begin
         span_sat = s[POS_WIDTH-1:0];
      end else if (s[SPAN_W-1]) begin
         span_sat = {1'b1, {(POS_WIDTH-1){1'b0}}};
      end else begin
         span_sat = {1'b0, {(POS_WIDTH-1){1'b1}}};
      end
   endfunction

endpackage

[rtl/spline_tangent_generator.sv]
// spline_tangent_generator: kochanek-bartels tangents for a stream of 3d segments
// one module; depends on stg_pkg for widths, codes and rounding helpers
//
// Each request word is one spline segment (begin and end position, signed
// Q15.16, and a flag for the last segment of a run). Response words are
// tangents: for a segment with a predecessor, first the begin tangent of
// the new segment, then the end tangent of the previous one; the first
// segment of a run gives its own span as its begin tangent; a last segment
// adds one more word, its end tangent, equal to its begin tangent. So a
// segment yields one to three response words, and last_of_run marks the
// final one. The datapath is three registered stages (span, weight
// products, then sum/round/saturate into the result register, which hands
// out one response word per cycle while rsp_ready is high); new request
// words enter behind earlier ones until every stage is full, so throughput
// is set by the response port alone. A request word passes the span,
// product and result registers before its first response word is on the
// port. Tension, continuity and bias are written over the apb-style port
// (byte addresses 0, 4, 8); each write to one of them starts a sequencer
// that recomputes the four tangent weights on one shared pair of
// multipliers, during which req_ready is held low.

module spline_tangent_generator (
   input  logic                                  clock,
   input  logic                                  reset,
   // request words: one segment each
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [stg_pkg::POS_WIDTH-1:0]  req_start_x,
   input  logic signed [stg_pkg::POS_WIDTH-1:0]  req_start_y,
   input  logic signed [stg_pkg::POS_WIDTH-1:0]  req_start_z,
   input  logic signed [stg_pkg::POS_WIDTH-1:0]  req_finish_x,
   input  logic signed [stg_pkg::POS_WIDTH-1:0]  req_finish_y,
   input  logic signed [stg_pkg::POS_WIDTH-1:0]  req_finish_z,
   input  logic                                  req_final_segment,
   // response words: one tangent each
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [stg_pkg::POS_WIDTH-1:0]  rsp_tangent_x,
   output logic signed [stg_pkg::POS_WIDTH-1:0]  rsp_tangent_y,
   output logic signed [stg_pkg::POS_WIDTH-1:0]  rsp_tangent_z,
   output logic                                  rsp_tangent_kind,
   output logic                                  rsp_which_segment,
   output logic                                  rsp_last_of_run,
   // register port
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [stg_pkg::CSR_ADDR_W-1:0]        paddr,
   input  logic [stg_pkg::CSR_DATA_W-1:0]        pwdata,
   output logic [stg_pkg::CSR_DATA_W-1:0]        prdata,
   output logic                                  pready
);
   import stg_pkg::*;

   // ------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------
   logic                  csr_wr;
   logic                  csr_hit;
   logic [REG_IDX_W-1:0]  csr_idx;
   reg_type               tension_ff;
   reg_type               continuity_ff;
   reg_type               bias_ff;

   assign pready  = 1'b1;
   assign csr_wr  = psel & penable & pwrite & pready;
   assign csr_idx = paddr[CSR_ADDR_W-1:2];
   // a write past the bias register changes nothing and starts no recompute
   assign csr_hit = csr_wr & ((csr_idx == REG_TENSION) || (csr_idx == REG_CONTINUITY) ||
                              (csr_idx == REG_BIAS));

   always_ff @(posedge clock) begin
      if (reset) begin
         tension_ff    <= '0;
         continuity_ff <= '0;
         bias_ff       <= '0;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_TENSION:    tension_ff    <= pwdata[REG_W-1:0];
            REG_CONTINUITY: continuity_ff <= pwdata[REG_W-1:0];
            REG_BIAS:       bias_ff       <= pwdata[REG_W-1:0];
            default: ;
         endcase
      end
   end

   // readback, sign-extended to the bus width
   always_comb begin
      case (csr_idx)
         REG_TENSION:    prdata = {{(CSR_DATA_W-REG_W){tension_ff[REG_W-1]}}, tension_ff};
         REG_CONTINUITY: prdata = {{(CSR_DATA_W-REG_W){continuity_ff[REG_W-1]}},
                                   continuity_ff};
         REG_BIAS:       prdata = {{(CSR_DATA_W-REG_W){bias_ff[REG_W-1]}}, bias_ff};
         default:        prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // weight sequencer: k = round(0.5 * (1-t) * (1+-c) * (1+-b))
   // even step forms the c*b pair, odd step multiplies by (1-t) and rounds
   // ------------------------------------------------------------------
   logic                  seq_busy_ff;
   logic [STEP_W-1:0]     seq_step_ff;
   logic [COEF_IDX_W-1:0] seq_cidx;
   term_type              t_ext, c_ext, b_ext;
   term_type              u_term, c_plus, c_minus, b_plus, b_minus;
   term_type              fac_c, fac_b;
   pair_type              pair_in, pair_ff;
   triple_type            triple_in;
   coef_type              coef_ff [NUM_COEF];

   assign seq_cidx = seq_step_ff[STEP_W-1:1];
   assign t_ext    = {tension_ff[REG_W-1], tension_ff};
   assign c_ext    = {continuity_ff[REG_W-1], continuity_ff};
   assign b_ext    = {bias_ff[REG_W-1], bias_ff};
   assign u_term   = ONE_TERM - t_ext;
   assign c_plus   = ONE_TERM + c_ext;
   assign c_minus  = ONE_TERM - c_ext;
   assign b_plus   = ONE_TERM + b_ext;
   assign b_minus  = ONE_TERM - b_ext;

   // k0 begin/prev, k1 begin/cur, k2 end/prev, k3 end/cur
   always_comb begin
      case (seq_cidx)
         2'd0:    begin fac_c = c_plus;  fac_b = b_plus;  end
         2'd1:    begin fac_c = c_minus; fac_b = b_minus; end
         2'd2:    begin fac_c = c_minus; fac_b = b_plus;  end
         2'd3:    begin fac_c = c_plus;  fac_b = b_minus; end
         default: begin fac_c = c_plus;  fac_b = b_plus;  end
      endcase
   end

   assign pair_in   = pair_type'(fac_c) * pair_type'(fac_b);
   assign triple_in = triple_type'(pair_ff) * triple_type'(u_term);

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_busy_ff <= 1'b0;
         seq_step_ff <= '0;
      end else if (csr_hit) begin
         // a later write restarts the pass with the newest values
         seq_busy_ff <= 1'b1;
         seq_step_ff <= '0;
      end else if (seq_busy_ff) begin
         seq_step_ff <= seq_step_ff + STEP_W'(1);
         if (seq_step_ff == STEP_W'(2 * NUM_COEF - 1)) begin
            seq_busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (seq_busy_ff && !seq_step_ff[0]) begin
         pair_ff <= pair_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_COEF; k++) begin
            coef_ff[k] <= COEF_RESET;
         end
      end else if (seq_busy_ff && seq_step_ff[0] && !csr_hit) begin
         coef_ff[seq_cidx] <= coef_round(triple_in);
      end
   end

   // ------------------------------------------------------------------
   // pipeline flow control
   // ------------------------------------------------------------------
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic s1_move, s2_move, s3_done;
   logic s1_free, s2_free, s3_free;
   logic req_take, rsp_take;
   logic s3_last;

   assign rsp_take  = s3_valid_ff & rsp_ready;
   assign s3_done   = rsp_take & s3_last;
   assign s3_free   = ~s3_valid_ff | s3_done;
   assign s2_move   = s2_valid_ff & s3_free;
   assign s2_free   = ~s2_valid_ff | s2_move;
   assign s1_move   = s1_valid_ff & s2_free;
   assign s1_free   = ~s1_valid_ff | s1_move;
   assign req_ready = s1_free & ~seq_busy_ff;
   assign req_take  = req_valid & req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_move) begin
            s2_valid_ff <= 1'b1;
         end else if (s2_move) begin
            s2_valid_ff <= 1'b0;
         end
         if (s2_move) begin
            s3_valid_ff <= 1'b1;
         end else if (s3_done) begin
            s3_valid_ff <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // stage 1: span = finish - start, exact
   // ------------------------------------------------------------------
   pos_type  in_start  [NUM_AXES];
   pos_type  in_finish [NUM_AXES];
   span_type s1_span_ff [NUM_AXES];
   logic     s1_final_ff;

   assign in_start[0]  = req_start_x;
   assign in_start[1]  = req_start_y;
   assign in_start[2]  = req_start_z;
   assign in_finish[0] = req_finish_x;
   assign in_finish[1] = req_finish_y;
   assign in_finish[2] = req_finish_z;

   always_ff @(posedge clock) begin
      if (req_take) begin
         for (int j = 0; j < NUM_AXES; j++) begin
            s1_span_ff[j] <= span_type'(in_finish[j]) - span_type'(in_start[j]);
         end
         s1_final_ff <= req_final_segment;
      end
   end

   // ------------------------------------------------------------------
   // joint state: span of the segment before, and whether there is one
   // ------------------------------------------------------------------
   span_type prev_span_ff [NUM_AXES];
   logic     have_prev_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         have_prev_ff <= 1'b0;
         for (int j = 0; j < NUM_AXES; j++) begin
            prev_span_ff[j] <= '0;
         end
      end else if (s1_move) begin
         // a last segment closes the run
         have_prev_ff <= ~s1_final_ff;
         for (int j = 0; j < NUM_AXES; j++) begin
            prev_span_ff[j] <= s1_span_ff[j];
         end
      end
   end

   // ------------------------------------------------------------------
   // stage 2: four weight products per axis
   // ------------------------------------------------------------------
   prod_type s2_bp_ff [NUM_AXES];   // k0 * previous span
   prod_type s2_bc_ff [NUM_AXES];   // k1 * current span
   prod_type s2_ep_ff [NUM_AXES];   // k2 * previous span
   prod_type s2_ec_ff [NUM_AXES];   // k3 * current span
   span_type s2_span_ff [NUM_AXES];
   logic     s2_prev_ff;
   logic     s2_final_ff;

   always_ff @(posedge clock) begin
      if (s1_move) begin
         for (int j = 0; j < NUM_AXES; j++) begin
            s2_bp_ff[j]   <= prod_type'(coef_ff[0]) * prod_type'(prev_span_ff[j]);
            s2_bc_ff[j]   <= prod_type'(coef_ff[1]) * prod_type'(s1_span_ff[j]);
            s2_ep_ff[j]   <= prod_type'(coef_ff[2]) * prod_type'(prev_span_ff[j]);
            s2_ec_ff[j]   <= prod_type'(coef_ff[3]) * prod_type'(s1_span_ff[j]);
            s2_span_ff[j] <= s1_span_ff[j];
         end
         s2_prev_ff  <= have_prev_ff;
         s2_final_ff <= s1_final_ff;
      end
   end

   // ------------------------------------------------------------------
   // stage 3: sum, round, saturate; result register
   // ------------------------------------------------------------------
   pos_type    s3_begin_ff [NUM_AXES];
   pos_type    s3_end_ff   [NUM_AXES];
   logic       s3_prev_ff;
   logic       s3_final_ff;
   logic [1:0] s3_pos_ff;
   logic [1:0] s3_count;

   always_ff @(posedge clock) begin
      if (s2_move) begin
         for (int j = 0; j < NUM_AXES; j++) begin
            if (s2_prev_ff) begin
               s3_begin_ff[j] <= tangent_round(sum_type'(s2_bp_ff[j]) +
                                               sum_type'(s2_bc_ff[j]));
            end else begin
               // first segment of a run: its own span
               s3_begin_ff[j] <= span_sat(s2_span_ff[j]);
            end
            s3_end_ff[j] <= tangent_round(sum_type'(s2_ep_ff[j]) + sum_type'(s2_ec_ff[j]));
         end
         s3_prev_ff  <= s2_prev_ff;
         s3_final_ff <= s2_final_ff;
      end
   end

   // which of the segment's words is on the port
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_pos_ff <= '0;
      end else if (s2_move) begin
         s3_pos_ff <= '0;
      end else if (rsp_take) begin
         s3_pos_ff <= s3_pos_ff + 2'd1;
      end
   end

   assign s3_count = 2'd1 + {1'b0, s3_prev_ff} + {1'b0, s3_final_ff};
   assign s3_last  = (s3_pos_ff == (s3_count - 2'd1));

   // word order: begin of current, end of previous, end of a last segment
   pos_type out_tan [NUM_AXES];

   always_comb begin
      case (s3_pos_ff)
         2'd0: begin
            out_tan           = s3_begin_ff;
            rsp_tangent_kind  = KIND_BEGIN;
            rsp_which_segment = SEG_CURRENT;
         end
         2'd1: begin
            if (s3_prev_ff) begin
               out_tan           = s3_end_ff;
               rsp_tangent_kind  = KIND_END;
               rsp_which_segment = SEG_PREVIOUS;
            end else begin
               out_tan           = s3_begin_ff;
               rsp_tangent_kind  = KIND_END;
               rsp_which_segment = SEG_CURRENT;
            end
         end
         default: begin
            out_tan           = s3_begin_ff;
            rsp_tangent_kind  = KIND_END;
            rsp_which_segment = SEG_CURRENT;
         end
      endcase
   end

   assign rsp_valid       = s3_valid_ff;
   assign rsp_tangent_x   = out_tan[0];
   assign rsp_tangent_y   = out_tan[1];
   assign rsp_tangent_z   = out_tan[2];
   assign rsp_last_of_run = s3_last;

endmodule

[rtl/stg_checker.sv]
// stg_checker: port-level assertions for spline_tangent_generator, bound to the top
// depends on stg_pkg for widths and result codes
module stg_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic signed [stg_pkg::POS_WIDTH-1:0]  rsp_tangent_x,
   input logic signed [stg_pkg::POS_WIDTH-1:0]  rsp_tangent_y,
   input logic signed [stg_pkg::POS_WIDTH-1:0]  rsp_tangent_z,
   input logic                                  rsp_tangent_kind,
   input logic                                  rsp_which_segment,
   input logic                                  rsp_last_of_run,
   input logic                                  pready
);
   import stg_pkg::*;

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tangent_x) &&
         $stable(rsp_tangent_y) && $stable(rsp_tangent_z) && $stable(rsp_tangent_kind) &&
         $stable(rsp_which_segment) && $stable(rsp_last_of_run))
      else $error("response word changed while stalled");

   // a tangent of the previous segment is always its end tangent
   a_prev_is_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_which_segment == SEG_PREVIOUS) |-> (rsp_tangent_kind == KIND_END))
      else $error("previous segment word is not an end tangent");

   // the end tangent of the current segment only closes a run
   a_close_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_tangent_kind == KIND_END) && (rsp_which_segment == SEG_CURRENT)
         |-> rsp_last_of_run)
      else $error("closing tangent not marked last");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_pready_high: assert property (@(posedge clock) disable iff (reset)
      pready)
      else $error("pready low");

endmodule

bind spline_tangent_generator stg_checker u_stg_checker (.*);
